/* rtl/gne_pkg.sv */
// Shared constants and types for the grid neighbor enumerator.
package gne_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int SIZE_W   = 7;
	localparam int VTX_W    = 12;
	localparam int PROD_W   = 2 * SIZE_W;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

	localparam logic OP_BLOCK = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic             done;
		logic [VTX_W-1:0] quot;
		logic [COL_W-1:0] rem;
	} div_res_t;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v == '0)
			r = SIZE_W'(1);
		else if (v > maxv)
			r = maxv;
		else
			r = v;
		return r;
	endfunction

endpackage

/* rtl/gne_div.sv */
// Radix-2 restoring divider splitting a vertex number into row and column.
module gne_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [gne_pkg::VTX_W-1:0] dividend,
	input  logic [gne_pkg::SIZE_W-1:0] divisor,
	output gne_pkg::div_res_t         res
);
	import gne_pkg::*;

	localparam int TRIAL_W = COL_W + 1;
	localparam int CNT_W   = $clog2(VTX_W + 1);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [VTX_W-1:0]   quo_q;
	logic [COL_W-1:0]   rem_q;
	logic [TRIAL_W-1:0] dvs_q;
	logic [TRIAL_W-1:0] trial;
	logic               fit;

	assign trial = {rem_q, quo_q[VTX_W-1]};
	assign fit   = (trial >= dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(VTX_W);
		end else if (busy_q) begin
			if (cnt_q == '0)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= TRIAL_W'(divisor);
		end else if (busy_q && cnt_q != '0) begin
			quo_q <= {quo_q[VTX_W-2:0], fit};
			rem_q <= fit ? COL_W'(trial - dvs_q) : COL_W'(trial);
		end
	end

	assign res.done = busy_q && (cnt_q == '0);
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule

/* rtl/grid_neighbor_enumerator.sv */
// Top level: blocked-cell map and 4-neighbor enumeration for a grid graph.
//
// Input stream s_*: s_tuser is the op (0 = block cell, 1 = neighbor query);
// s_tdata carries vertex, cell_row and cell_col. Output stream m_*: one
// transaction per open neighbor in the order up, down, left, right, with
// m_tlast on the final one. A query with no open neighbor, or with a vertex
// outside the grid, gives a single transaction with valid_res low.
// Configuration: cfg_we writes cfg_data into grid_rows (index 0) or
// grid_cols (index 1); write only while the block is idle.
// The map lives in a 64-row by 64-bit RAM with a registered read port.
// After reset a clearing pass writes every row, holding s_tready low. A
// block op reads the row, then sets the cell's bit and writes it back. A
// query is accepted, runs through the bit-serial row/column divider, then
// reads the rows above, at and below the vertex, then gives one result per
// cycle while m_tready is high. An out-of-grid vertex skips the divider.
// A result waits in the output register while m_tready is low; the next
// transaction is taken once the last result of a query is loaded.
module grid_neighbor_enumerator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [gne_pkg::S_TDATA_W-1:0]  s_tdata,  // vertex[11:0], cell_row[17:12], cell_col[23:18]
	input  logic                           s_tuser,  // op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [gne_pkg::M_TDATA_W-1:0]  m_tdata,  // neighbor[11:0]
	output logic [gne_pkg::M_TUSER_W-1:0]  m_tuser,  // valid_res[0], bad_vertex[1]
	output logic                           m_tlast,
	input  logic                           cfg_we,
	input  logic [gne_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gne_pkg::SIZE_W-1:0]     cfg_data
);
	import gne_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_BLK_RD, ST_BLK_WR, ST_DIV,
		ST_RD_UP, ST_RD_MID, ST_RD_DN, ST_RD_END, ST_EMIT
	} state_t;

	state_t state_q;

	logic [SIZE_W-1:0] rows_cfg_q, cols_cfg_q;
	logic [SIZE_W-1:0] rows_eff, cols_eff;
	logic [PROD_W-1:0] cells;

	logic [VTX_W-1:0] in_vertex;
	logic [ROW_W-1:0] in_row;
	logic [COL_W-1:0] in_col;
	logic             in_fire;

	logic [ROW_W-1:0] clr_cnt_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [VTX_W-1:0] vtx_q;
	logic             bad_q;
	logic             up_open_q, left_open_q, right_open_q;
	logic [3:0]       mask_q;

	logic [MAX_COLS-1:0] map_mem [MAX_ROWS];
	logic [MAX_COLS-1:0] rd_data_s1;
	logic [ROW_W-1:0]    raddr, waddr;
	logic [MAX_COLS-1:0] wdata;
	logic                we;

	div_res_t div_res;
	logic     div_start;

	logic             out_free;
	logic [VTX_W-1:0] nb_val;
	logic [3:0]       mask_nxt;
	logic             dn_ok;
	logic             right_ok;
	logic [VTX_W-1:0] cols_v;

	assign in_vertex = s_tdata[VTX_W-1:0];
	assign in_row    = s_tdata[VTX_W +: ROW_W];
	assign in_col    = s_tdata[VTX_W + ROW_W +: COL_W];
	assign in_fire   = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);

	assign rows_eff = eff_size(rows_cfg_q, SIZE_W'(MAX_ROWS));
	assign cols_eff = eff_size(cols_cfg_q, SIZE_W'(MAX_COLS));
	assign cells    = PROD_W'(rows_eff) * PROD_W'(cols_eff);
	assign cols_v   = VTX_W'(cols_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= SIZE_W'(64);
			cols_cfg_q <= SIZE_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_ROWS: rows_cfg_q <= cfg_data;
				REG_GRID_COLS: cols_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign div_start = in_fire && (s_tuser == OP_QUERY) && (PROD_W'(in_vertex) < cells);

	gne_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_vertex),
		.divisor  (cols_eff),
		.res      (div_res)
	);

	// map RAM
	always_comb begin
		raddr = row_q;
		we    = 1'b0;
		waddr = row_q;
		wdata = rd_data_s1;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_cnt_q;
				wdata = '0;
			end
			ST_BLK_WR: begin
				we    = 1'b1;
				wdata = rd_data_s1 | (MAX_COLS'(1) << col_q);
			end
			ST_RD_UP:  raddr = row_q - ROW_W'(1);
			ST_RD_MID: raddr = row_q;
			ST_RD_DN:  raddr = row_q + ROW_W'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			map_mem[waddr] <= wdata;
		rd_data_s1 <= map_mem[raddr];
	end

	assign dn_ok    = (SIZE_W'(row_q) + SIZE_W'(1)) < rows_eff;
	assign right_ok = (SIZE_W'(col_q) + SIZE_W'(1)) < cols_eff;
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		nb_val   = '0;
		mask_nxt = mask_q;
		priority if (mask_q[0]) begin
			nb_val      = vtx_q - cols_v;
			mask_nxt[0] = 1'b0;
		end else if (mask_q[1]) begin
			nb_val      = vtx_q + cols_v;
			mask_nxt[1] = 1'b0;
		end else if (mask_q[2]) begin
			nb_val      = vtx_q - VTX_W'(1);
			mask_nxt[2] = 1'b0;
		end else if (mask_q[3]) begin
			nb_val      = vtx_q + VTX_W'(1);
			mask_nxt[3] = 1'b0;
		end else begin
			nb_val = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_cnt_q    <= '0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= '0;
			m_tlast      <= 1'b0;
			bad_q        <= 1'b0;
			mask_q       <= '0;
			row_q        <= '0;
			col_q        <= '0;
			vtx_q        <= '0;
			up_open_q    <= 1'b0;
			left_open_q  <= 1'b0;
			right_open_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_EMIT)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + ROW_W'(1);
					if (clr_cnt_q == ROW_W'(MAX_ROWS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_fire) begin
						row_q <= in_row;
						col_q <= in_col;
						vtx_q <= in_vertex;
						if (s_tuser == OP_BLOCK) begin
							if (SIZE_W'(in_row) < rows_eff && SIZE_W'(in_col) < cols_eff)
								state_q <= ST_BLK_RD;
						end else if (div_start) begin
							bad_q   <= 1'b0;
							state_q <= ST_DIV;
						end else begin
							bad_q   <= 1'b1;
							mask_q  <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_BLK_RD: state_q <= ST_BLK_WR;
				ST_BLK_WR: state_q <= ST_IDLE;
				ST_DIV: begin
					if (div_res.done) begin
						row_q   <= div_res.quot[ROW_W-1:0];
						col_q   <= div_res.rem;
						state_q <= ST_RD_UP;
					end
				end
				ST_RD_UP: state_q <= ST_RD_MID;
				ST_RD_MID: begin
					up_open_q <= !rd_data_s1[col_q];
					state_q   <= ST_RD_DN;
				end
				ST_RD_DN: begin
					left_open_q  <= !rd_data_s1[col_q - COL_W'(1)];
					right_open_q <= !rd_data_s1[col_q + COL_W'(1)];
					state_q      <= ST_RD_END;
				end
				ST_RD_END: begin
					mask_q[0] <= (row_q != '0) && up_open_q;
					mask_q[1] <= dn_ok && !rd_data_s1[col_q];
					mask_q[2] <= (col_q != '0) && left_open_q;
					mask_q[3] <= right_ok && right_open_q;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						if (bad_q || mask_q == '0) begin
							m_tdata <= '0;
							m_tuser <= {bad_q, 1'b0};
							m_tlast <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							m_tdata <= M_TDATA_W'(nb_val);
							m_tuser <= 2'b01;
							m_tlast <= (mask_nxt == '0);
							mask_q  <= mask_nxt;
							if (mask_nxt == '0)
								state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/gne_chk.sv */
// Port-level checker for the grid neighbor enumerator, bound to the top level.
module gne_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [gne_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [gne_pkg::M_TUSER_W-1:0] m_tuser,
	input logic                          m_tlast
);
	import gne_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output transaction changed while stalled");

	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
		else $error("bad vertex result not a lone final transaction");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == '0))
		else $error("result without neighbor not final or not zero");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_QUERY) |=> !s_tready)
		else $error("query accepted back to back");

endmodule

bind grid_neighbor_enumerator gne_chk u_gne_chk (.*);

/* test/tb_top.sv */
// Self-checking testbench for grid_neighbor_enumerator: blocked-map updates and neighbor queries.
`timescale 1ns / 100ps

module tb_top;
	import gne_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int HOLD_OFF       = 200;

	typedef struct packed {
		logic [VTX_W-1:0] neighbor;
		logic             valid_res;
		logic             bad_vertex;
		logic             last;
	} nb_result_t;

	class grid_scoreboard;
		bit               blocked_cells [MAX_ROWS][MAX_COLS];
		logic [SIZE_W-1:0] rows_reg;
		logic [SIZE_W-1:0] cols_reg;
		nb_result_t       expected_q [$];
		int               errors;
		int               blocks;
		int               queries;
		int               results_seen;
		int               off_grid;
		int               isolated;

		function new();
			for (int r = 0; r < MAX_ROWS; r++)
				for (int c = 0; c < MAX_COLS; c++)
					blocked_cells[r][c] = 1'b0;
			rows_reg = 7'd64;
			cols_reg = 7'd64;
		endfunction

		function int effective_dim(logic [SIZE_W-1:0] v, int maxv);
			if (v == 0)
				return 1;
			if (v > maxv)
				return maxv;
			return v;
		endfunction

		function int grid_rows();
			return effective_dim(rows_reg, MAX_ROWS);
		endfunction

		function int grid_cols();
			return effective_dim(cols_reg, MAX_COLS);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
			if (idx == REG_GRID_ROWS)
				rows_reg = val;
			else
				cols_reg = val;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void add_expected(nb_result_t res);
			expected_q = {expected_q, res};
		endfunction

		function void note_input(logic op, logic [VTX_W-1:0] vtx, logic [ROW_W-1:0] r,
			logic [COL_W-1:0] c);
			int rows, cols, vr, vc, nr, nc, n;
			int dr [4];
			int dc [4];
			nb_result_t res;
			dr = '{-1, 1, 0, 0};
			dc = '{0, 0, -1, 1};
			rows = grid_rows();
			cols = grid_cols();
			if (op == OP_BLOCK) begin
				blocks++;
				if (r < rows && c < cols)
					blocked_cells[r][c] = 1'b1;
				return;
			end
			queries++;
			res = '0;
			res.last = 1'b1;
			if (vtx >= rows * cols) begin
				res.bad_vertex = 1'b1;
				add_expected(res);
				off_grid++;
				return;
			end
			vr = vtx / cols;
			vc = vtx % cols;
			n = 0;
			for (int i = 0; i < 4; i++) begin
				nr = vr + dr[i];
				nc = vc + dc[i];
				if (nr >= 0 && nc >= 0 && nr < rows && nc < cols && !blocked_cells[nr][nc]) begin
					res.neighbor   = VTX_W'(nr * cols + nc);
					res.valid_res  = 1'b1;
					res.bad_vertex = 1'b0;
					res.last       = 1'b0;
					add_expected(res);
					n++;
				end
			end
			if (n == 0) begin
				res = '0;
				res.last = 1'b1;
				add_expected(res);
				isolated++;
			end else begin
				expected_q[expected_q.size() - 1].last = 1'b1;
			end
		endfunction

		function void check_result(logic [VTX_W-1:0] nb, logic vr, logic bv, logic lst);
			nb_result_t exp_r;
			results_seen++;
			if (expected_q.size() == 0) begin
				$display("%0t: expected no result, actual neighbor=%0h valid_res=%b bad_vertex=%b last=%b",
					$time, nb, vr, bv, lst);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (nb !== exp_r.neighbor) begin
				$display("%0t: neighbor expected %0d actual %0d", $time, exp_r.neighbor, nb);
				errors++;
			end
			if (vr !== exp_r.valid_res) begin
				$display("%0t: valid_res expected %b actual %b", $time, exp_r.valid_res, vr);
				errors++;
			end
			if (bv !== exp_r.bad_vertex) begin
				$display("%0t: bad_vertex expected %b actual %b", $time, exp_r.bad_vertex, bv);
				errors++;
			end
			if (lst !== exp_r.last) begin
				$display("%0t: last expected %b actual %b", $time, exp_r.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [M_TUSER_W-1:0]   m_tuser;
	logic                   m_tlast;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [SIZE_W-1:0]      cfg_data;

	grid_scoreboard sb;
	int  send_idle_pct;
	int  stall_pct;
	bit  hold_req;
	int  quiet_cycles;

	grid_neighbor_enumerator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_OFF;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[VTX_W-1:0], m_tuser[0], m_tuser[1], m_tlast);
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("grid_neighbor_enumerator test failed");
		$finish;
	end

	// all driving tasks start and end at a falling edge
	task automatic send_item(logic op, logic [VTX_W-1:0] vtx, logic [ROW_W-1:0] r,
		logic [COL_W-1:0] c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {c, r, vtx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_input(op, vtx, r, c);
		@(negedge clk);
	endtask

	task automatic send_random();
		int rows, cols;
		logic op;
		logic [VTX_W-1:0] vtx;
		logic [ROW_W-1:0] r;
		logic [COL_W-1:0] c;
		rows = sb.grid_rows();
		cols = sb.grid_cols();
		op  = ($urandom_range(0, 99) < 30) ? OP_BLOCK : OP_QUERY;
		vtx = VTX_W'($urandom);
		r   = ROW_W'($urandom);
		c   = COL_W'($urandom);
		if ($urandom_range(0, 99) < 85) begin
			vtx = VTX_W'($urandom_range(0, rows * cols - 1));
			r   = ROW_W'($urandom_range(0, rows - 1));
			c   = COL_W'($urandom_range(0, cols - 1));
		end
		send_item(op, vtx, r, c);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_sizes(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] cols);
		cfg_we    <= 1'b1;
		cfg_index <= REG_GRID_ROWS;
		cfg_data  <= rows;
		@(negedge clk);
		cfg_index <= REG_GRID_COLS;
		cfg_data  <= cols;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(REG_GRID_ROWS, rows);
		sb.set_reg(REG_GRID_COLS, cols);
		@(negedge clk);
	endtask

	initial begin
		logic [SIZE_W-1:0] rr, cc;
		sb = new();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_BLOCK;
		cfg_we = 1'b0;
		cfg_index = REG_GRID_ROWS;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: corners, interior, isolation, far map corner
		send_item(OP_QUERY, 12'd0, 6'd0, 6'd0);
		send_item(OP_QUERY, 12'd4095, 6'd0, 6'd0);
		send_item(OP_QUERY, 12'd65, 6'd0, 6'd0);
		send_item(OP_QUERY, 12'd63, 6'd0, 6'd0);
		send_item(OP_BLOCK, 12'd0, 6'd0, 6'd1);
		send_item(OP_BLOCK, 12'd0, 6'd1, 6'd0);
		send_item(OP_QUERY, 12'd0, 6'd0, 6'd0);
		send_item(OP_BLOCK, 12'hfff, 6'd63, 6'd63);
		send_item(OP_QUERY, 12'd4094, 6'd0, 6'd0);
		wait_idle();
		// small grid: blocks outside it, vertices past its end
		write_sizes(7'd3, 7'd5);
		send_item(OP_BLOCK, 12'd0, 6'd5, 6'd2);
		send_item(OP_BLOCK, 12'd0, 6'd2, 6'd7);
		send_item(OP_QUERY, 12'd15, 6'd0, 6'd0);
		send_item(OP_QUERY, 12'd4095, 6'd0, 6'd0);
		send_item(OP_QUERY, 12'd7, 6'd0, 6'd0);
		send_item(OP_QUERY, 12'd11, 6'd0, 6'd0);
		wait_idle();
		// zero sizes act as one
		write_sizes(7'd0, 7'd0);
		send_item(OP_QUERY, 12'd0, 6'd0, 6'd0);
		send_item(OP_QUERY, 12'd1, 6'd0, 6'd0);
		send_item(OP_BLOCK, 12'd0, 6'd0, 6'd1);
		wait_idle();
		// oversize values clamp to the maximum
		write_sizes(7'd127, 7'd127);
		send_item(OP_QUERY, 12'd4095, 6'd0, 6'd0);
		send_item(OP_QUERY, 12'd4030, 6'd0, 6'd0);
		wait_idle();

		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: begin rr = 7'd64; cc = 7'd64; end
				1: begin rr = 7'd1;  cc = 7'd64; end
				2: begin rr = 7'd64; cc = 7'd1;  end
				3: begin rr = 7'd2;  cc = 7'd3;  end
				5: begin rr = 7'd0;  cc = 7'd127; end
				7: begin rr = 7'd8;  cc = 7'd8;  end
				8: begin rr = SIZE_W'($urandom); cc = SIZE_W'($urandom); end
				9: begin rr = 7'd64; cc = 7'd64; end
				default: begin
					rr = SIZE_W'($urandom_range(1, 64));
					cc = SIZE_W'($urandom_range(1, 64));
				end
			endcase
			write_sizes(rr, cc);
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 82; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 82; end
				default: begin send_idle_pct = 10; stall_pct = 10; end
			endcase
			for (int k = 0; k < 44; k++) begin
				if (phase == 0 && k == 10)
					hold_req = 1'b1;
				if (phase == 6 && k == 22) begin
					s_tvalid <= 1'b0;
					while (sb.pending() != 0)
						@(negedge clk);
				end
				send_random();
			end
			wait_idle();
		end

		$display("covered %0d transactions in: %0d blocks, %0d queries, %0d results checked",
			sb.blocks + sb.queries, sb.blocks, sb.queries, sb.results_seen);
		$display("%0d off-grid queries, %0d queries with no open neighbor, %0d mismatches",
			sb.off_grid, sb.isolated, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("grid_neighbor_enumerator test passed");
		else
			$display("grid_neighbor_enumerator test failed");
		$finish;
	end

endmodule

/* files.f */
rtl/gne_pkg.sv
rtl/gne_div.sv
rtl/grid_neighbor_enumerator.sv
rtl/gne_chk.sv
test/tb_top.sv
